/* hdl/i2c_master_message_sequencer_core_assert.svh */
`ifndef I2C_MASTER_MESSAGE_SEQUENCER_CORE_ASSERT_SVH
`define I2C_MASTER_MESSAGE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define I2C_MSEQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c_mseq: same-cycle property violated");

// Next-cycle implication, sampled on clk, off during reset.
`define I2C_MSEQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c_mseq: next-cycle property violated");

`endif

/* hdl/i2c_mseq_pkg.sv */
package i2c_mseq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_EVENT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_CONT     = 3'd1,
    ACT_START    = 3'd2,
    ACT_ADDR     = 3'd3,
    ACT_DATA     = 3'd4,
    ACT_RCV      = 3'd5,
    ACT_RCV_STOP = 3'd6,
    ACT_STOP     = 3'd7
  } action_t;

  localparam logic [3:0] ST_START      = 4'd0;
  localparam logic [3:0] ST_RSTART     = 4'd1;
  localparam logic [3:0] ST_ADDRW_ACK  = 4'd2;
  localparam logic [3:0] ST_ADDRW_NACK = 4'd3;
  localparam logic [3:0] ST_DATAW_ACK  = 4'd4;
  localparam logic [3:0] ST_ADDRR_ACK  = 4'd6;
  localparam logic [3:0] ST_DATAR_ACK  = 4'd8;
  localparam logic [3:0] ST_DATAR_NACK = 4'd9;
  localparam logic [3:0] ST_ADDR2_ACK  = 4'd10;

  localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
  localparam logic [1:0] CFG_READ_MODE      = 2'd1;
  localparam logic [1:0] CFG_MESSAGE_LENGTH = 2'd2;

  localparam logic [6:0] ADDR_MASK  = 7'h7f;
  localparam logic [8:0] CURSOR_MAX = 9'h1ff;

  typedef struct packed {
    action_t    action;
    logic [7:0] drive_byte;
    logic [7:0] received_byte;
    logic [8:0] position;
    logic       ack_enable;
    logic       busy_res;
    logic       error;
  } result_t;

endpackage

/* hdl/i2c_master_message_sequencer_core.sv */
// Message sequencer for a single-message I2C master transfer.
// cfg_*: register writes (index 0 slave address, 1 read mode, 2 message
//   length); ready outside reset, write only while no transaction is in flight.
// in_*: one transaction per item; tuser carries the op (load, start, bus
//   status event, no-op), tdata the status code, load index, load byte and
//   received bus byte.
// out_*: exactly one result transaction per input item, in order; tuser
//   carries the controller action, tdata the drive byte, received byte,
//   position, ack enable, busy and error.
// An accepted item is registered in the middle stage and then in the output
//   register, where out_tvalid rises. The state update and the message
//   buffer access happen at acceptance; the buffer read for a transmit byte
//   is registered in the buffer and joins its item in the output register.
// Throughput: one item per cycle while out_tready does not stall, set by
//   the buffer's write and read ports and the scalar state update.
// Reset: synchronous rst_n clears the configuration, the position and busy,
//   sets ack enable, and empties both stages; in_tready and cfg_ready stay low
//   while it is held. The buffer is not cleared.
// A stalled out_tready holds the output register; one more item is held in
//   the middle stage, after which in_tready drops.
module i2c_master_message_sequencer_core #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // op
  input  logic [31:0] in_tdata,   // status_code, load_index, load_byte, bus_rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // action
  output logic [31:0] out_tdata   // drive_byte, received_byte, position, ack_enable,
                                  // busy_res, error
);

  `include "i2c_master_message_sequencer_core_assert.svh"

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic                  s1_valid, s1_ready, s1_mem;
  i2c_mseq_pkg::result_t s1_res, out_res;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [7:0]            mem_wdata, mem_rdata;
  logic                  start_out, nack_in;

  assign cfg_ready = rst_n;

  i2c_mseq_ctrl #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .op(i2c_mseq_pkg::op_t'(in_tuser)),
    .status_code(in_tdata[3:0]),
    .load_index(in_tdata[11:4]),
    .load_byte(in_tdata[19:12]),
    .bus_rx_byte(in_tdata[27:20]),
    .s1_ready(s1_ready),
    .s1_valid(s1_valid),
    .s1_res(s1_res),
    .s1_mem(s1_mem),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr)
  );

  i2c_mseq_mem #(
    .DEPTH(BUFFER_BYTES),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  i2c_mseq_out u_out (
    .clk(clk),
    .rst_n(rst_n),
    .s1_valid(s1_valid),
    .s1_res(s1_res),
    .s1_mem(s1_mem),
    .mem_rdata(mem_rdata),
    .s1_ready(s1_ready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res(out_res)
  );

  assign out_tuser = out_res.action;
  assign out_tdata = {4'b0000, out_res.error, out_res.busy_res, out_res.ack_enable,
                      out_res.position, out_res.received_byte, out_res.drive_byte};

  assign start_out = out_tvalid && out_tuser == i2c_mseq_pkg::ACT_START;
  assign nack_in   = in_tvalid && in_tready && in_tuser == i2c_mseq_pkg::OP_EVENT &&
                     in_tdata[3:0] == i2c_mseq_pkg::ST_ADDRW_NACK;

  `I2C_MSEQ_ASSERT_IMP(a_stall_only_when_full, !in_tready, s1_valid)
  `I2C_MSEQ_ASSERT_IMP(a_mem_drive_clear, s1_valid && s1_mem, s1_res.drive_byte == 8'd0)
  `I2C_MSEQ_ASSERT_IMP(a_start_result, start_out, out_tdata[26:16] == 11'h600)
  `I2C_MSEQ_ASSERT_NXT(a_error_stops, nack_in, s1_valid && s1_res.error && !s1_res.busy_res)

endmodule

/* hdl/i2c_mseq_mem.sv */
module i2c_mseq_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/i2c_mseq_ctrl.sv */
module i2c_mseq_ctrl #(
  parameter int BUFFER_BYTES = 256,
  parameter int AW           = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [8:0]            cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  i2c_mseq_pkg::op_t     op,
  input  logic [3:0]            status_code,
  input  logic [7:0]            load_index,
  input  logic [7:0]            load_byte,
  input  logic [7:0]            bus_rx_byte,
  input  logic                  s1_ready,
  output logic                  s1_valid,
  output i2c_mseq_pkg::result_t s1_res,
  output logic                  s1_mem,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [7:0]            mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr
);

  localparam logic [19:0]   BW        = 20'(BUFFER_BYTES);
  localparam logic [AW-1:0] ADDR_LAST = AW'(BUFFER_BYTES - 1);

  function automatic logic [AW-1:0] buf_index(input logic [7:0] idx);
    logic [19:0] r;
    r = 20'(idx);
    for (int k = 7; k >= 0; k--) begin
      if (r >= (BW << k)) begin
        r = r - (BW << k);
      end
    end
    return AW'(r);
  endfunction

  logic [6:0]            slave_address_r;
  logic                  read_mode_r;
  logic [8:0]            message_length_r;
  logic [8:0]            rem_r, rem_nxt;
  logic [8:0]            cursor_r, cursor_nxt;
  logic [AW-1:0]         addr_r, addr_nxt;
  logic                  ack_r, ack_nxt;
  logic                  busy_r, busy_nxt;
  logic                  s1_valid_r;
  i2c_mseq_pkg::result_t s1_res_r, res_nxt;
  logic                  s1_mem_r, mem_nxt;
  logic                  accept;
  logic                  we_nxt, re_nxt;
  logic [8:0]            cursor_inc;
  logic [AW-1:0]         addr_inc;

  assign in_ready = rst_n && (!s1_valid_r || s1_ready);
  assign accept   = in_valid && in_ready;

  assign cursor_inc = cursor_r + 9'd1;
  assign addr_inc   = (cursor_r == i2c_mseq_pkg::CURSOR_MAX || addr_r == ADDR_LAST) ?
                      '0 : addr_r + AW'(1);

  always_comb begin
    rem_nxt    = rem_r;
    cursor_nxt = cursor_r;
    addr_nxt   = addr_r;
    ack_nxt    = ack_r;
    busy_nxt   = busy_r;
    mem_nxt    = 1'b0;
    we_nxt     = 1'b0;
    re_nxt     = 1'b0;
    mem_waddr  = addr_r;
    mem_wdata  = bus_rx_byte;
    res_nxt    = '0;
    res_nxt.action = i2c_mseq_pkg::ACT_NONE;
    unique case (op)
      i2c_mseq_pkg::OP_LOAD: begin
        we_nxt    = 1'b1;
        mem_waddr = buf_index(load_index);
        mem_wdata = load_byte;
      end
      i2c_mseq_pkg::OP_START: begin
        rem_nxt        = message_length_r;
        cursor_nxt     = '0;
        addr_nxt       = '0;
        busy_nxt       = 1'b1;
        ack_nxt        = 1'b1;
        res_nxt.action = i2c_mseq_pkg::ACT_START;
      end
      i2c_mseq_pkg::OP_EVENT: begin
        case (status_code) inside
          i2c_mseq_pkg::ST_START, i2c_mseq_pkg::ST_RSTART: begin
            res_nxt.action     = i2c_mseq_pkg::ACT_ADDR;
            res_nxt.drive_byte = {slave_address_r & i2c_mseq_pkg::ADDR_MASK, read_mode_r};
          end
          i2c_mseq_pkg::ST_ADDRW_ACK, i2c_mseq_pkg::ST_DATAW_ACK,
          i2c_mseq_pkg::ST_ADDR2_ACK: begin
            if (rem_r == '0) begin
              res_nxt.action = i2c_mseq_pkg::ACT_STOP;
              busy_nxt       = 1'b0;
            end else begin
              res_nxt.action = i2c_mseq_pkg::ACT_DATA;
              re_nxt         = 1'b1;
              mem_nxt        = 1'b1;
              cursor_nxt     = cursor_inc;
              addr_nxt       = addr_inc;
              rem_nxt        = rem_r - 9'd1;
            end
          end
          i2c_mseq_pkg::ST_ADDRR_ACK, i2c_mseq_pkg::ST_DATAR_ACK: begin
            if (status_code == i2c_mseq_pkg::ST_DATAR_ACK) begin
              res_nxt.action        = i2c_mseq_pkg::ACT_RCV;
              res_nxt.received_byte = bus_rx_byte;
              we_nxt                = 1'b1;
              cursor_nxt            = cursor_inc;
              addr_nxt              = addr_inc;
              if (rem_r != '0) begin
                rem_nxt = rem_r - 9'd1;
              end
            end else begin
              res_nxt.action = i2c_mseq_pkg::ACT_CONT;
            end
            if (rem_nxt == 9'd1) begin
              ack_nxt = 1'b0;
            end
          end
          i2c_mseq_pkg::ST_DATAR_NACK: begin
            res_nxt.action        = i2c_mseq_pkg::ACT_RCV_STOP;
            res_nxt.received_byte = bus_rx_byte;
            we_nxt                = 1'b1;
            cursor_nxt            = cursor_inc;
            addr_nxt              = addr_inc;
            busy_nxt              = 1'b0;
          end
          default: begin
            res_nxt.action = i2c_mseq_pkg::ACT_STOP;
            res_nxt.error  = 1'b1;
            busy_nxt       = 1'b0;
          end
        endcase
      end
      i2c_mseq_pkg::OP_NOP: begin
        res_nxt.action = i2c_mseq_pkg::ACT_NONE;
      end
      default: begin
        res_nxt.action = i2c_mseq_pkg::ACT_NONE;
      end
    endcase
    res_nxt.position   = cursor_nxt;
    res_nxt.ack_enable = ack_nxt;
    res_nxt.busy_res   = busy_nxt;
  end

  assign mem_we    = accept && we_nxt;
  assign mem_re    = accept && re_nxt;
  assign mem_raddr = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_address_r  <= '0;
      read_mode_r      <= 1'b0;
      message_length_r <= '0;
      rem_r            <= '0;
      cursor_r         <= '0;
      addr_r           <= '0;
      ack_r            <= 1'b1;
      busy_r           <= 1'b0;
      s1_valid_r       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          i2c_mseq_pkg::CFG_SLAVE_ADDRESS:  slave_address_r  <= cfg_data[6:0];
          i2c_mseq_pkg::CFG_READ_MODE:      read_mode_r      <= cfg_data[0];
          i2c_mseq_pkg::CFG_MESSAGE_LENGTH: message_length_r <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        rem_r    <= rem_nxt;
        cursor_r <= cursor_nxt;
        addr_r   <= addr_nxt;
        ack_r    <= ack_nxt;
        busy_r   <= busy_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_res_r <= res_nxt;
      s1_mem_r <= mem_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_res   = s1_res_r;
  assign s1_mem   = s1_mem_r;

endmodule

/* hdl/i2c_mseq_out.sv */
module i2c_mseq_out (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  s1_valid,
  input  i2c_mseq_pkg::result_t s1_res,
  input  logic                  s1_mem,
  input  logic [7:0]            mem_rdata,
  output logic                  s1_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output i2c_mseq_pkg::result_t out_res
);

  logic                  out_valid_r;
  i2c_mseq_pkg::result_t out_res_r, res_nxt;

  assign s1_ready = !out_valid_r || out_ready;

  always_comb begin
    res_nxt = s1_res;
    if (s1_mem) begin
      res_nxt.drive_byte = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
